// ===== rtl/utf8d_pkg.sv =====
// Shared types, constants and a helper function for the UTF-8 stream decoder.
// Used by the channel interfaces and by the decoder top level.
package utf8d_pkg;

  // Payload widths.
  localparam int ByteW  = 8;
  localparam int CodeW  = 32;
  localparam int CountW = 3;

  // Most results one input byte can produce: flush, value and terminator.
  localparam int MaxResults = 3;

  // Byte classification masks.
  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] SixBits   = 8'h3f;
  localparam logic [ByteW-1:0] SevenBits = 8'h7f;

  // One decoded result.
  typedef struct packed {
    logic [CodeW-1:0] code_value;
    logic             string_end;
  } result_t;

  // Length of the run of ones just below the top bit of a lead byte (0 to 7).
  function automatic logic [CountW-1:0] lead_run(input logic [ByteW-1:0] b);
    logic [CountW-1:0] run;
    logic              going;
    run   = '0;
    going = 1'b1;
    for (int i = ByteW - 2; i >= 0; i--) begin
      if (going && b[i]) begin
        run = run + CountW'(1);
      end else begin
        going = 1'b0;
      end
    end
    return run;
  endfunction

endpackage

// ===== rtl/utf8d_if.sv =====
// Valid/ready channel interfaces for the byte input and the code point output.
// Depends on utf8d_pkg for the payload widths.
interface utf8d_in_if;
  import utf8d_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface utf8d_out_if;
  import utf8d_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_value;
  logic             string_end;

  modport source (output valid, output code_value, output string_end, input ready);
  modport sink   (input valid, input code_value, input string_end, output ready);
endinterface

// ===== rtl/utf8_stream_decoder.sv =====
// UTF-8 style stream decoder: one byte per request in, code points out.
// Depends on utf8d_pkg and the channel interfaces in utf8d_if.sv.
// A byte's first result is registered and offered in the cycle after acceptance.
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is ready; a byte with more results holds the input while they drain.
// Reset (synchronous, rst_n low) closes any open sequence and empties the output.
module utf8_stream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  utf8d_in_if.sink           in_ch,
  utf8d_out_if.source        out_ch
);
  import utf8d_pkg::*;

  // Decoder state.
  logic [CountW-1:0] pend_r, pend_nxt;
  logic [CodeW-1:0]  part_r, part_nxt;
  logic              open_r, open_nxt;

  // Result register: up to three results, slot 0 is offered first.
  result_t           slot_r [MaxResults];
  result_t           grp_nxt [MaxResults];
  logic [1:0]        cnt_r;
  logic [1:0]        n_nxt;

  logic [ByteW-1:0]  b;
  logic [CountW-1:0] run;
  logic              is_cont;
  logic              zero_seen;
  logic              take;
  logic              pop;

  localparam result_t Term = '{code_value: '0, string_end: 1'b1};

  // Handshake: accept while the result register will be empty next cycle.
  assign pop          = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);
  assign take         = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.code_value = slot_r[0].code_value;
  assign out_ch.string_end = slot_r[0].string_end;

  assign b       = in_ch.in_byte;
  assign is_cont = ((b & ContMask) == ContTag);
  assign run     = lead_run(b);

  // Decode one byte into the next state and a group of results.
  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    open_nxt  = open_r;
    n_nxt     = 2'd0;
    zero_seen = 1'b0;
    for (int k = 0; k < MaxResults; k++) begin
      grp_nxt[k] = '0;
    end

    if (open_r && is_cont) begin
      // Continuation: shift in six bits, emit when the count is met.
      part_nxt = {part_r[CodeW-7:0], b[5:0]};
      pend_nxt = pend_r - CountW'(1);
      if (pend_nxt == '0) begin
        grp_nxt[n_nxt] = '{code_value: part_nxt, string_end: 1'b0};
        n_nxt          = n_nxt + 2'd1;
        pend_nxt       = '0;
        part_nxt       = '0;
        open_nxt       = 1'b0;
      end
    end else begin
      // Any other byte first flushes an open partial value.
      if (open_r) begin
        grp_nxt[n_nxt] = '{code_value: part_r, string_end: 1'b0};
        n_nxt          = n_nxt + 2'd1;
        pend_nxt       = '0;
        part_nxt       = '0;
        open_nxt       = 1'b0;
      end
      if (b == '0) begin
        // Zero byte ends the string; the end mark adds nothing more.
        grp_nxt[n_nxt] = Term;
        n_nxt          = n_nxt + 2'd1;
        zero_seen      = 1'b1;
      end else if (!b[ByteW-1]) begin
        grp_nxt[n_nxt] = '{code_value: CodeW'(b), string_end: 1'b0};
        n_nxt          = n_nxt + 2'd1;
      end else if (run == '0) begin
        // Lone continuation byte yields its low seven bits.
        grp_nxt[n_nxt] = '{code_value: CodeW'(b & SevenBits), string_end: 1'b0};
        n_nxt          = n_nxt + 2'd1;
      end else begin
        // Lead byte opens a sequence seeded by the bits under the run.
        pend_nxt = run;
        part_nxt = CodeW'(b & (SevenBits >> run));
        open_nxt = 1'b1;
      end
    end

    // End mark: flush what is open and close the string.
    if (in_ch.buffer_end && !zero_seen) begin
      if (open_nxt) begin
        grp_nxt[n_nxt] = '{code_value: part_nxt, string_end: 1'b0};
        n_nxt          = n_nxt + 2'd1;
      end
      grp_nxt[n_nxt] = Term;
      n_nxt          = n_nxt + 2'd1;
      pend_nxt       = '0;
      part_nxt       = '0;
      open_nxt       = 1'b0;
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
      open_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (take) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      open_r <= open_nxt;
      cnt_r  <= n_nxt;
      for (int k = 0; k < MaxResults; k++) begin
        slot_r[k] <= grp_nxt[k];
      end
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
      for (int k = 0; k < MaxResults - 1; k++) begin
        slot_r[k] <= slot_r[k+1];
      end
    end
  end

endmodule

// ===== tb/tb_utf8_stream_decoder.sv =====
// Self-checking testbench for the UTF-8 stream decoder: drives bytes, predicts
// code values and terminators, and compares every result field by field.
// Depends on utf8d_pkg, the channel interfaces and utf8_stream_decoder.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  // Top bit of the run of ones in a lead byte.
  localparam logic [ByteW-1:0] LeadRunTop = 8'h40;

  logic clk = 1'b0;
  logic rst_n;

  utf8d_in_if  in_ch ();
  utf8d_out_if out_ch ();

  utf8_stream_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Decoder state as predicted from the accepted byte stream.
  logic [CountW-1:0] pend_cnt = '0;
  logic [CodeW-1:0]  part_val = '0;
  logic              seq_open = 1'b0;

  // Code values and terminators still owed by the decoder, oldest first.
  result_t decoded_q[$];

  int  fail_count    = 0;
  int  bytes_sent    = 0;
  bit  src_gap_en    = 1'b1;
  bit  sink_stall_en = 1'b1;
  int  stall_left    = 0;

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic void push_code(logic [CodeW-1:0] value, logic term);
    result_t res;
    res.code_value = value;
    res.string_end = term;
    decoded_q.push_back(res);
  endfunction

  // An open sequence gives out what it has gathered and closes.
  function automatic void flush_partial();
    if (seq_open) begin
      push_code(part_val, 1'b0);
    end
    seq_open = 1'b0;
    pend_cnt = '0;
    part_val = '0;
  endfunction

  // Predict the results of one accepted byte and advance the decoder state.
  function automatic void decode_byte(logic [ByteW-1:0] b, logic last);
    logic [CountW-1:0] run;
    logic [ByteW-1:0]  mask;
    if (seq_open && (b & ContMask) == ContTag) begin
      // Continuation byte: shift in six more bits.
      part_val = (part_val << 6) | CodeW'(b & SixBits);
      pend_cnt = pend_cnt - CountW'(1);
      if (pend_cnt == '0) begin
        flush_partial();
      end
    end else begin
      // Any other byte breaks an open sequence before it is handled.
      flush_partial();
      if (b == '0) begin
        push_code('0, 1'b1);
        return;
      end
      if (!b[ByteW-1]) begin
        push_code(CodeW'(b), 1'b0);
      end else begin
        run  = '0;
        mask = SevenBits;
        for (int i = 6; i >= 0 && b[i]; i--) begin
          run  = run + CountW'(1);
          mask = mask >> 1;
        end
        if (run == '0) begin
          // Lone continuation byte stands for its low seven bits.
          push_code(CodeW'(b & SevenBits), 1'b0);
        end else begin
          pend_cnt = run;
          part_val = CodeW'(b & mask);
          seq_open = 1'b1;
        end
      end
    end
    if (last) begin
      flush_partial();
      push_code('0, 1'b1);
    end
  endfunction

  // Offer one byte, hold it until the request is taken, then idle at random if gaps are on.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.in_byte    = b;
    in_ch.buffer_end = last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    decode_byte(b, last);
    bytes_sent++;
    gap = src_gap_en ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering bytes and wait until every predicted result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Result side back-pressure.
  always @(negedge clk) begin
    if (stall_left == 0 && sink_stall_en) begin
      stall_left = idle_len();
    end
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: code_value %h string_end %b",
               out_ch.code_value, out_ch.string_end);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.code_value !== want.code_value) begin
          $error("code_value mismatch: expected %h, got %h",
                 want.code_value, out_ch.code_value);
          fail_count++;
        end
        if (out_ch.string_end !== want.string_end) begin
          $error("string_end mismatch: expected %b, got %b",
                 want.string_end, out_ch.string_end);
          fail_count++;
        end
      end
    end
  end

  task automatic test_single_byte_codes();
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_multibyte_sequences();
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // All-ones lead expects seven continuations; the value wraps to 32 bits.
  task automatic test_all_ones_lead();
    send_byte(8'hff, 1'b0);
    repeat (7) send_byte(8'hbf, 1'b0);
  endtask

  // A plain byte inside an open sequence flushes it and then stands alone.
  task automatic test_early_break();
    send_byte(8'he2, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_lone_continuation();
    send_byte(8'h80, 1'b0);
  endtask

  // Zero byte flushes the open partial value and ends the string.
  task automatic test_zero_byte();
    send_byte(8'hc3, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // End mark: flush, value and terminator from one byte; zero byte gives one
  // terminator only.
  task automatic test_end_mark();
    send_byte(8'hc3, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Mostly well-formed sequences with random content, plus noise, zero bytes
  // and truncated sequences.
  task automatic test_random_stream();
    int               start;
    int               r;
    int               run;
    int               conts;
    logic [ByteW-1:0] lead;
    start = bytes_sent;
    while (bytes_sent - start < 76) begin
      if ($urandom_range(0, 11) == 0) begin
        src_gap_en    = 1'($urandom_range(0, 1));
        sink_stall_en = 1'($urandom_range(0, 1));
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        wait_drained();
      end else if (r < 15) begin
        send_byte(ByteW'($urandom), $urandom_range(0, 9) == 0);
      end else if (r < 19) begin
        send_byte('0, 1'($urandom_range(0, 1)));
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
        if (run == 0) begin
          send_byte(ByteW'($urandom_range(1, 127)), $urandom_range(0, 19) == 0);
        end else begin
          if (run == 7) begin
            lead = 8'hff;
          end else begin
            lead = (8'hff << (7 - run))
                 | (ByteW'($urandom) & ((LeadRunTop >> run) - 8'h01));
          end
          conts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, run - 1) : run;
          send_byte(lead, conts == 0 && $urandom_range(0, 19) == 0);
          for (int k = 1; k <= conts; k++) begin
            send_byte(ContTag | ByteW'($urandom_range(0, 63)),
                      k == conts && $urandom_range(0, 12) == 0);
          end
        end
      end
    end
  endtask

  // Watchdog for a hung handshake.
  initial begin
    #1ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.buffer_end = 1'b0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_single_byte_codes();
    test_multibyte_sequences();
    test_all_ones_lead();
    test_early_break();
    test_lone_continuation();
    test_zero_byte();
    test_end_mark();
    wait_drained();
    test_random_stream();

    // Let the last results drain, then watch for stray ones.
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
